// ----- rtl/core/nroot_pkg.sv -----
// Package for the Newton nth-root block: sequencer states and fixed widths.
// No dependencies.
package nroot_pkg;
  localparam int unsigned VAL_W = 24;
  localparam int unsigned ORD_W = 4;
  localparam int unsigned TOL_W = 16;
  localparam int unsigned LIM_W = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_POW,
    ST_DERIV,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } nroot_state_t;
endpackage

// ----- rtl/core/newton_nth_root.sv -----
// Newton nth-root top level: sequencer, shared multiplier and divider.
// Depends on nroot_pkg and nroot_div.
//
// Usage: an input beat (in_radicand, in_root_order) is taken when in_valid
// is high and in_stall low, and only while the block is idle. One result
// beat follows on out_*, held until out_stall is low. The block then
// returns to idle.
// Each Newton step runs in order: the step check, the shared 24x24
// multiplier for y^(n-1) and y^n, the derivative, the bit-serial divider
// and then the update.
// Reset clears the sequencer, loads tolerance 66 and iteration limit 64.
// While out_stall is high the result is held and no input is taken.
// cfg_wr writes register cfg_index (0 tolerance, 1 iteration limit).
module newton_nth_root #(
  parameter int unsigned MAX_ORDER     = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nroot_pkg::VAL_W-1:0] in_radicand,
  input  logic [nroot_pkg::ORD_W-1:0] in_root_order,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nroot_pkg::VAL_W-1:0] out_root_value,
  output logic                       out_converged,
  output logic [7:0]                 out_iterations_used,
  output logic                       out_overflow,
  input  logic                       cfg_wr,
  input  logic [nroot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);
  import nroot_pkg::*;

  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned DF_W   = VAL_W + ORD_W + 1;
  localparam int unsigned NUM_W  = VAL_W + FRACTION_BITS;
  localparam logic [VAL_W-1:0] ONE_FX  = VAL_W'(64'd1 << FRACTION_BITS);
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);

  nroot_state_t state_r, state_nxt;

  logic [TOL_W-1:0] tol_r;
  logic [LIM_W-1:0] lim_r;
  logic [VAL_W-1:0] a_r, y_r, pw_r, pwl_r, mag_r;
  logic [ORD_W-1:0] n_r, k_r;
  logic [LIM_W-1:0] steps_r;
  logic             conv_r, ovf_r, neg_r;
  logic [DF_W-1:0]  df_r;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [VAL_W-1:0]  prod_sat;
  logic              prod_ovf;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [ORD_W-1:0]  n_in;
  logic [NUM_W+1:0]  ynew;
  logic [VAL_W-1:0]  yclamp, ydiff;
  logic              yovf;

  assign n_in = (in_root_order < ORD_W'(2)) ? ORD_W'(2)
              : (in_root_order > ORD_MAX) ? ORD_MAX : in_root_order;

  assign prod     = pw_r * y_r;
  assign prod_sh  = prod >> FRACTION_BITS;
  assign prod_ovf = |prod_sh[PROD_W-1:VAL_W];
  assign prod_sat = prod_ovf ? VAL_MAX : prod_sh[VAL_W-1:0];

  nroot_div #(.NUM_W(NUM_W), .DEN_W(DF_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({mag_r, FRACTION_BITS'(0)}),
    .den   (df_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    if (neg_r) ynew = (NUM_W+2)'(y_r) + (NUM_W+2)'(div_quo);
    else       ynew = (NUM_W+2)'(y_r) - (NUM_W+2)'(div_quo);
    yovf   = 1'b0;
    yclamp = ynew[VAL_W-1:0];
    if (ynew[NUM_W+1])                  yclamp = '0;
    else if (|ynew[NUM_W:VAL_W]) begin
      yclamp = VAL_MAX;
      yovf   = 1'b1;
    end
    ydiff = (yclamp > y_r) ? yclamp - y_r : y_r - yclamp;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_STEP;
      ST_STEP:   state_nxt = (steps_r < lim_r) ? ST_POW : ST_DONE;
      ST_POW:    if (k_r == n_r) state_nxt = ST_DERIV;
      ST_DERIV:  state_nxt = (df_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = (ydiff < VAL_W'(tol_r)) ? ST_DONE : ST_STEP;
      ST_DONE:   if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    div_start = (state_r == ST_DERIV) && (df_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tol_r   <= TOL_W'(66);
      lim_r   <= LIM_W'(64);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_TOLERANCE:  tol_r <= cfg_data;
          CFG_ITER_LIMIT: lim_r <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        a_r     <= in_radicand;
        n_r     <= n_in;
        y_r     <= ONE_FX;
        steps_r <= '0;
        conv_r  <= 1'b0;
        ovf_r   <= 1'b0;
      end
      ST_STEP: begin
        pw_r <= ONE_FX;
        k_r  <= ORD_W'(1);
      end
      ST_POW: begin
        pw_r  <= prod_sat;
        ovf_r <= ovf_r | prod_ovf;
        if (k_r == n_r - ORD_W'(1)) pwl_r <= prod_sat;
        if (k_r == n_r) begin
          df_r  <= DF_W'(n_r) * DF_W'(pwl_r);
          neg_r <= prod_sat < a_r;
          mag_r <= (prod_sat < a_r) ? a_r - prod_sat : prod_sat - a_r;
        end
        k_r <= k_r + ORD_W'(1);
      end
      ST_DERIV: if (df_r == '0) conv_r <= 1'b1;
      ST_UPDATE: begin
        y_r     <= yclamp;
        ovf_r   <= ovf_r | yovf;
        steps_r <= steps_r + 1'b1;
        if (ydiff < VAL_W'(tol_r)) conv_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_root_value      = y_r;
  assign out_converged       = conv_r;
  assign out_iterations_used = steps_r;
  assign out_overflow        = ovf_r;

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (steps_r <= lim_r)) else $error("step count over limit");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV)) else $error("divider done outside divide");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(y_r)) else $error("result changed under stall");
endmodule

// ----- rtl/core/nroot_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module nroot_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam logic [CNT_W-1:0] NUM_BITS = CNT_W'(NUM_W);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= NUM_BITS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DEN_W]) begin
        rem_r <= diff[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = busy_r && (cnt_r == CNT_W'(1)) && !start;
  assign quo  = quo_r;
endmodule
